// ===== rtl/m4au_pkg.sv =====
// Shared operation codes, item types and fixed-point helpers for the matrix unit.
package m4au_pkg;

    localparam int unsigned ElemWidth = 32;

    typedef enum logic [3:0] {
        OP_WR_ACC  = 4'd0,
        OP_WR_OPND = 4'd1,
        OP_ADD     = 4'd2,
        OP_SUB     = 4'd3,
        OP_MUL_R   = 4'd4,
        OP_MUL_L   = 4'd5,
        OP_SCALE   = 4'd6,
        OP_TRANS   = 4'd7,
        OP_READ    = 4'd8
    } t_op;

    typedef struct packed {
        logic [3:0]        operation;
        logic [1:0]        row;
        logic [1:0]        col;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               overflow;
    } t_out_item;

    // Clamp a 33-bit exact sum or difference to 32 bits.
    function automatic logic [32:0] sat33(input logic signed [32:0] v);
        logic [32:0] r;
        if (v[32] != v[31]) begin
            r = {1'b1, v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

// ===== rtl/m4au_if.sv =====
// Valid/ready channel interface carrying one item payload.
interface m4au_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/m4au_cell.sv =====
// One matrix element cell: holds an accumulator and an operand element and passes them on.
module m4au_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic                i_load_a,
    input  logic signed [31:0]  i_a,
    input  logic                i_load_b,
    input  logic signed [31:0]  i_b,
    input  logic signed [31:0]  i_a_prev,
    input  logic signed [31:0]  i_b_prev,
    output logic signed [31:0]  o_a,
    output logic signed [31:0]  o_b
);
    logic signed [31:0] r_a;
    logic signed [31:0] r_b;

    // Shifting moves both matrices one step along the chain; loads win over shifts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
        end else begin
            if (i_load_a) begin
                r_a <= i_a;
            end else if (i_shift) begin
                r_a <= i_a_prev;
            end
            if (i_load_b) begin
                r_b <= i_b;
            end else if (i_shift) begin
                r_b <= i_b_prev;
            end
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;
endmodule

// ===== rtl/m4au_mac.sv =====
// Shared multiply-accumulate unit with floor shift and 32-bit saturation.
module m4au_mac #(
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned DIM       = 4
) (
    input  logic               i_clk,
    input  logic               i_clear,
    input  logic               i_en,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    output logic signed [31:0] o_res,
    output logic               o_sat
);
    localparam int unsigned AccW = 64 + $clog2(DIM) + 1;

    logic signed [63:0]     r_prod;
    logic                   r_acc_en;
    logic signed [AccW-1:0] r_acc;
    logic signed [AccW-1:0] shifted;

    // The product is registered before it enters the sum, and the enable is registered
    // beside it, so the sum takes the product in the cycle after it is registered.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 64'(i_x) * 64'(i_y);
        end
        r_acc_en <= i_en;
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_acc_en) begin
            r_acc <= r_acc + AccW'(r_prod);
        end
    end

    assign shifted = r_acc >>> FRAC_BITS;

    always_comb begin
        if (shifted > AccW'(signed'(33'sh0_7FFF_FFFF))) begin
            o_res = 32'sh7FFF_FFFF;
            o_sat = 1'b1;
        end else if (shifted < AccW'(-(64'sh8000_0000))) begin
            o_res = 32'sh8000_0000;
            o_sat = 1'b1;
        end else begin
            o_res = shifted[31:0];
            o_sat = 1'b0;
        end
    end
endmodule

// ===== rtl/matrix4x4_arith_unit.sv =====
// Top level of the fixed-point matrix unit: control, cell chain, shared multiply-add.
//
// The block holds an accumulator matrix and an operand matrix of DIM x DIM signed
// Q(32-FRAC_BITS).FRAC_BITS elements in a chain of cells, one per element in
// row-major order. Each accepted input transfer yields exactly one output transfer.
// One item is processed at a time, and the input is held off until the result
// transfer of the previous item has been taken. Element writes, reads and unused
// codes go straight to the result. Add and subtract rotate the whole chain once
// and land each result in the chain tail as the elements go by. Scale holds each
// element at the chain head for the shared multiply-add. Transpose rotates once to
// take a snapshot of the accumulator into a DIM*DIM entry register memory and once
// more to write the transposed elements back. A matrix product takes a snapshot of
// both matrices in the same rotation and then computes the elements one at a time
// on the single shared multiply-add unit; it is the longest item.
module matrix4x4_arith_unit #(
    parameter int unsigned DIM       = 4,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    m4au_if.sink   i_in,
    m4au_if.source o_out
);
    import m4au_pkg::*;

    localparam int unsigned NElem = DIM * DIM;
    localparam int unsigned IdxW  = $clog2(NElem);
    localparam int unsigned DW    = $clog2(DIM);
    localparam int unsigned KW    = $clog2(DIM + 3);

    typedef enum logic [2:0] {
        S_IDLE, S_ROT, S_TRANS, S_MUL_K, S_MUL_FIN, S_SNAP, S_DONE
    } t_state;

    t_state            r_state;
    t_in_item          r_item;
    logic [IdxW:0]     r_cnt;
    logic [IdxW-1:0]   r_oidx;
    logic [DW-1:0]     r_orow;
    logic [DW-1:0]     r_ocol;
    logic [KW-1:0]     r_k;
    logic              r_ovf;
    logic              r_out_valid;
    t_out_item         r_out;
    logic signed [31:0] r_rd;

    logic signed [31:0] a_q [NElem];
    logic signed [31:0] b_q [NElem];
    logic signed [31:0] a_d [NElem];
    logic               ld_a [NElem];
    logic               ld_b [NElem];
    logic signed [31:0] wr_a;
    logic               shift;

    // Snapshot memories used by the matrix product and the transpose.
    logic signed [31:0] mem_a [NElem];
    logic signed [31:0] mem_b [NElem];
    logic signed [31:0] r_ma;
    logic signed [31:0] r_mb;

    logic        idx_ok;
    logic [IdxW-1:0] widx;
    logic        is_mul;
    logic [DW-1:0] kk;
    logic [IdxW-1:0] ra_idx;
    logic [IdxW-1:0] rb_idx;
    logic [IdxW-1:0] src0;

    logic signed [32:0] addsub;
    logic [32:0]        sat_as;
    logic               mac_clear;
    logic               mac_en;
    logic signed [31:0] mac_res;
    logic               mac_sat;
    logic signed [31:0] mac_x;

    assign idx_ok = (32'(r_item.row) < DIM) && (32'(r_item.col) < DIM);
    assign widx   = IdxW'(32'(r_item.row) * DIM + 32'(r_item.col));
    assign is_mul = (r_item.operation == OP_MUL_R) || (r_item.operation == OP_MUL_L);
    assign i_in.ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Element currently at the chain head (index 0) during a rotation.
    assign addsub = (r_item.operation == OP_ADD) ? (33'(a_q[0]) + 33'(b_q[0]))
                                                 : (33'(a_q[0]) - 33'(b_q[0]));
    assign sat_as = sat33(addsub);

    // On a shift the tail takes wr_a: the head element or the value the operation writes
    // back. Scale shifts only in the last step for each element; the transpose write-back
    // shifts in the cycle after the registered snapshot read.
    assign src0  = IdxW'(r_cnt);
    assign shift = ((r_state == S_ROT) && (r_cnt < (IdxW+1)'(NElem)) &&
                    ((r_item.operation != OP_SCALE) || (32'(r_k) == 2))) ||
                   ((r_state == S_TRANS) && (r_cnt != '0));

    always_comb begin
        case (r_item.operation)
            OP_ADD, OP_SUB: wr_a = sat_as[31:0];
            OP_SCALE:       wr_a = mac_res;
            OP_TRANS:       wr_a = (r_state == S_TRANS) ? r_ma : a_q[0];
            default:        wr_a = a_q[0];
        endcase
    end

    // Chain wiring: cell i takes the next cell's value; the last takes wr_a.
    always_comb begin
        for (int i = 0; i < NElem; i++) begin
            a_d[i]  = (i == NElem - 1) ? wr_a : a_q[(i + 1) % NElem];
            ld_a[i] = 1'b0;
            ld_b[i] = 1'b0;
        end
        if (r_state == S_SNAP && r_item.operation == OP_WR_ACC && idx_ok) begin
            ld_a[widx] = 1'b1;
        end
        if (r_state == S_SNAP && r_item.operation == OP_WR_OPND && idx_ok) begin
            ld_b[widx] = 1'b1;
        end
        if (r_state == S_MUL_FIN) begin
            ld_a[r_oidx] = 1'b1;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NElem; g++) begin : g_cell
            m4au_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (shift),
                .i_load_a (ld_a[g]),
                .i_a      ((r_state == S_MUL_FIN) ? mac_res : r_item.value),
                .i_load_b (ld_b[g]),
                .i_b      (r_item.value),
                .i_a_prev (a_d[g]),
                .i_b_prev (b_q[(g + 1) % NElem]),
                .o_a      (a_q[g]),
                .o_b      (b_q[g])
            );
        end
    endgenerate

    // Product indices: output element (r_orow, r_ocol), step kk. During the transpose
    // write-back the same row and column counters walk the destination order.
    assign kk = DW'(r_k);
    always_comb begin
        if (r_state == S_TRANS) begin
            ra_idx = IdxW'(32'(r_ocol) * DIM + 32'(r_orow));
            rb_idx = '0;
        end else if (r_item.operation == OP_MUL_R) begin
            ra_idx = IdxW'(32'(r_orow) * DIM + 32'(kk));
            rb_idx = IdxW'(32'(kk) * DIM + 32'(r_ocol));
        end else begin
            ra_idx = IdxW'(32'(kk) * DIM + 32'(r_ocol));
            rb_idx = IdxW'(32'(r_orow) * DIM + 32'(kk));
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift && r_state == S_ROT) begin
            mem_a[src0] <= a_q[0];
            mem_b[src0] <= b_q[0];
        end
        r_ma <= mem_a[ra_idx];
        r_mb <= mem_b[rb_idx];
    end

    // Scale streams the head element through the multiplier, one element per pass.
    assign mac_x     = (r_item.operation == OP_SCALE) ? a_q[0] : r_ma;
    assign mac_clear = (r_state == S_MUL_K && r_k == '0) ||
                       (r_state == S_ROT && r_item.operation == OP_SCALE && r_k == '0);
    assign mac_en    = (r_state == S_MUL_K && 32'(r_k) >= 1 && 32'(r_k) <= DIM) ||
                       (r_state == S_ROT && r_item.operation == OP_SCALE && r_k == '0);

    m4au_mac #(.FRAC_BITS(FRAC_BITS), .DIM(DIM)) u_mac (
        .i_clk   (i_clk),
        .i_clear (mac_clear),
        .i_en    (mac_en),
        .i_x     ((r_item.operation == OP_SCALE) ? mac_x : r_ma),
        .i_y     ((r_item.operation == OP_SCALE) ? r_item.value : r_mb),
        .o_res   (mac_res),
        .o_sat   (mac_sat)
    );

    // Sequencer. Rotation for scale holds each element at the head while it loads the
    // product, accumulates, then writes back while shifting.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_oidx      <= '0;
            r_orow      <= '0;
            r_ocol      <= '0;
            r_k         <= '0;
            r_ovf       <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_item <= i_in.data;
                        r_cnt  <= '0;
                        r_oidx <= '0;
                        r_orow <= '0;
                        r_ocol <= '0;
                        r_k    <= '0;
                        r_ovf  <= 1'b0;
                        r_rd   <= '0;
                        r_state <= S_SNAP;
                    end
                end
                S_SNAP: begin
                    if (r_item.operation == OP_READ && idx_ok) begin
                        r_rd <= a_q[widx];
                    end
                    if (r_item.operation == OP_ADD || r_item.operation == OP_SUB ||
                        r_item.operation == OP_SCALE || r_item.operation == OP_TRANS ||
                        is_mul) begin
                        r_state <= S_ROT;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_ROT: begin
                    if (r_cnt == (IdxW+1)'(NElem)) begin
                        r_cnt <= '0;
                        r_k   <= '0;
                        if (is_mul) begin
                            r_state <= S_MUL_K;
                        end else if (r_item.operation == OP_TRANS) begin
                            r_state <= S_TRANS;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        if (r_item.operation == OP_SCALE) begin
                            r_k <= (32'(r_k) == 2) ? '0 : r_k + 1'b1;
                        end
                        if (shift) begin
                            r_cnt <= r_cnt + 1'b1;
                            if ((r_item.operation == OP_ADD ||
                                 r_item.operation == OP_SUB) && sat_as[32]) begin
                                r_ovf <= 1'b1;
                            end
                            if (r_item.operation == OP_SCALE && mac_sat) begin
                                r_ovf <= 1'b1;
                            end
                        end
                    end
                end
                S_TRANS: begin
                    if (r_cnt == (IdxW+1)'(NElem)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        if (32'(r_ocol) == DIM - 1) begin
                            r_ocol <= '0;
                            r_orow <= r_orow + 1'b1;
                        end else begin
                            r_ocol <= r_ocol + 1'b1;
                        end
                    end
                end
                S_MUL_K: begin
                    if (32'(r_k) == DIM + 1) begin
                        r_state <= S_MUL_FIN;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_MUL_FIN: begin
                    if (mac_sat) begin
                        r_ovf <= 1'b1;
                    end
                    r_k <= '0;
                    if (32'(r_oidx) == NElem - 1) begin
                        r_state <= S_DONE;
                    end else begin
                        r_oidx  <= r_oidx + 1'b1;
                        if (32'(r_ocol) == DIM - 1) begin
                            r_ocol <= '0;
                            r_orow <= r_orow + 1'b1;
                        end else begin
                            r_ocol <= r_ocol + 1'b1;
                        end
                        r_state <= S_MUL_K;
                    end
                end
                S_DONE: begin
                    r_out.read_value <= r_rd;
                    r_out.overflow   <= r_ovf;
                    r_out_valid      <= 1'b1;
                    r_state          <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== test/matrix4x4_arith_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the matrix unit: directed and random item streams.
module matrix4x4_arith_unit_tb;
    import m4au_pkg::*;

    localparam int Dim = 4;
    localparam int FracBits = 16;
    localparam int NumElem = Dim * Dim;
    localparam longint CycleLimit = 4_000_000;

    logic i_clk;
    logic i_rst_n;

    m4au_if #(.T(t_in_item))  in_ch ();
    m4au_if #(.T(t_out_item)) out_ch ();

    matrix4x4_arith_unit #(.DIM(Dim), .FRAC_BITS(FracBits)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // Predicted contents of the two matrices, row-major.
    logic signed [31:0] acc_shadow [NumElem];
    logic signed [31:0] opnd_shadow [NumElem];

    t_out_item   result_queue [$];
    int          error_count;
    int          result_count;
    longint      cycle_count;
    int          op_count [16];
    bit          idle_enable;    // random idling on both sides
    bit          sink_hold;      // long receiver hold-off requested
    int          hold_cycles;

    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("%0t: timeout with %0d results outstanding", $time, result_queue.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Clamp a wide value into the 32-bit range, flagging saturation.
    function automatic logic signed [31:0] clamp32(input logic signed [71:0] v,
                                                   inout bit ovf);
        if (v > 72'sh7FFF_FFFF) begin
            ovf = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -72'sh8000_0000) begin
            ovf = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Apply one item to the shadow matrices and return the expected result.
    function automatic t_out_item predict_matrix_op(input t_in_item it);
        t_out_item          res;
        bit                 ovf;
        logic signed [31:0] tmp [NumElem];
        logic signed [71:0] sum;
        int                 idx;
        ovf = 1'b0;
        res.read_value = '0;
        idx = it.row * Dim + it.col;
        case (it.operation)
            OP_WR_ACC:  acc_shadow[idx] = it.value;
            OP_WR_OPND: opnd_shadow[idx] = it.value;
            OP_ADD, OP_SUB: begin
                for (int i = 0; i < NumElem; i++) begin
                    sum = (it.operation == OP_ADD)
                        ? 72'(acc_shadow[i]) + 72'(opnd_shadow[i])
                        : 72'(acc_shadow[i]) - 72'(opnd_shadow[i]);
                    acc_shadow[i] = clamp32(sum, ovf);
                end
            end
            OP_MUL_R, OP_MUL_L: begin
                for (int r = 0; r < Dim; r++) begin
                    for (int c = 0; c < Dim; c++) begin
                        sum = '0;
                        for (int k = 0; k < Dim; k++) begin
                            if (it.operation == OP_MUL_R) begin
                                sum += 72'(acc_shadow[r*Dim+k]) * 72'(opnd_shadow[k*Dim+c]);
                            end else begin
                                sum += 72'(opnd_shadow[r*Dim+k]) * 72'(acc_shadow[k*Dim+c]);
                            end
                        end
                        tmp[r*Dim+c] = clamp32(sum >>> FracBits, ovf);
                    end
                end
                acc_shadow = tmp;
            end
            OP_SCALE: begin
                for (int i = 0; i < NumElem; i++) begin
                    sum = 72'(acc_shadow[i]) * 72'(it.value);
                    acc_shadow[i] = clamp32(sum >>> FracBits, ovf);
                end
            end
            OP_TRANS: begin
                for (int r = 0; r < Dim; r++) begin
                    for (int c = 0; c < Dim; c++) begin
                        tmp[c*Dim+r] = acc_shadow[r*Dim+c];
                    end
                end
                acc_shadow = tmp;
            end
            OP_READ:    res.read_value = acc_shadow[idx];
            default: ;
        endcase
        res.overflow = ovf;
        return res;
    endfunction

    // Drive one item at the falling edge and hold it until the transfer happens.
    // Valid stays high afterwards so the next item can follow without a gap; the
    // caller drops it once the stream ends.
    task automatic send_item(input logic [3:0] op, input logic [1:0] row,
                             input logic [1:0] col, input logic signed [31:0] value);
        t_in_item it;
        it.operation = op;
        it.row = row;
        it.col = col;
        it.value = value;
        while (idle_enable && $urandom_range(99) < 34) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        result_queue.push_back(predict_matrix_op(it));
        op_count[op]++;
        @(negedge i_clk);
    endtask

    // Receiver ready: random idling, plus a long hold-off when requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (sink_hold) begin
            out_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            out_ch.ready <= !(idle_enable && $urandom_range(99) < 34);
        end
    end

    // Compare each output transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            result_count++;
            if (result_queue.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         out_ch.data);
            end else begin
                want = result_queue.pop_front();
                if (out_ch.data.read_value !== want.read_value) begin
                    error_count++;
                    $display("%0t: read_value expected %h actual %h", $time,
                             want.read_value, out_ch.data.read_value);
                end
                if (out_ch.data.overflow !== want.overflow) begin
                    error_count++;
                    $display("%0t: overflow expected %b actual %b", $time,
                             want.overflow, out_ch.data.overflow);
                end
            end
        end
    end

    task automatic wait_drained();
        while (result_queue.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom();
            default: return 32'($signed($urandom_range(262143)) - 131072);
        endcase
    endfunction

    // Every operation with extreme and ordinary element values.
    task automatic test_directed();
        send_item(OP_READ, 2'd3, 2'd3, 32'sd0);
        send_item(OP_WR_ACC, 2'd0, 2'd0, 32'sh7FFF_FFFF);
        send_item(OP_WR_ACC, 2'd3, 2'd3, 32'sh8000_0000);
        send_item(OP_WR_OPND, 2'd0, 2'd0, 32'sh7FFF_FFFF);
        send_item(OP_WR_OPND, 2'd3, 2'd3, 32'sh8000_0000);
        send_item(OP_ADD, 2'd0, 2'd0, 32'sd0);          // saturates both corners
        send_item(OP_READ, 2'd0, 2'd0, 32'sd0);
        send_item(OP_SUB, 2'd0, 2'd0, 32'sd0);
        send_item(OP_WR_ACC, 2'd1, 2'd2, 32'sh0003_0000);
        send_item(OP_TRANS, 2'd0, 2'd0, 32'sd0);
        send_item(OP_READ, 2'd2, 2'd1, 32'sd0);
        send_item(OP_MUL_R, 2'd0, 2'd0, 32'sd0);
        send_item(OP_MUL_L, 2'd0, 2'd0, 32'sd0);
        send_item(OP_SCALE, 2'd0, 2'd0, 32'shFFFF_0000);   // negate
        send_item(OP_SCALE, 2'd0, 2'd0, 32'sh7FFF_FFFF);
        send_item(OP_SCALE, 2'd0, 2'd0, 32'sh8000_0000);
        send_item(OP_READ, 2'd3, 2'd3, 32'sd0);
        send_item(4'd9, 2'd1, 2'd1, 32'sh1234_5678);  // unused codes change nothing
        send_item(4'd15, 2'd3, 2'd0, 32'shFFFF_FFFF);
        send_item(OP_READ, 2'd1, 2'd1, 32'sd0);
        in_ch.valid <= 1'b0;
        wait_drained();
    endtask

    // Moderate values half of the time so products stay in range, with corners and full-range values mixed in.
    task automatic test_random(input int count);
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 30) begin
                send_item(OP_WR_ACC, 2'($urandom()), 2'($urandom()), pick_value());
            end else if (roll < 55) begin
                send_item(OP_WR_OPND, 2'($urandom()), 2'($urandom()), pick_value());
            end else if (roll < 70) begin
                send_item(OP_READ, 2'($urandom()), 2'($urandom()), $urandom());
            end else if (roll < 97) begin
                send_item(4'($urandom_range(OP_ADD, OP_TRANS)), 2'($urandom()),
                          2'($urandom()), pick_value());
            end else begin
                send_item(4'($urandom_range(9, 15)), 2'($urandom()), 2'($urandom()),
                          $urandom());
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    // Stall the receiver long enough for the block to back up its input.
    task automatic test_backpressure();
        sink_hold = 1'b1;
        fork
            test_random(6);
            begin
                while (hold_cycles < 300) @(negedge i_clk);
                sink_hold = 1'b0;
            end
        join
        wait_drained();   // the sender pauses here until everything is back
    endtask

    initial begin
        cycle_count = 0;
        error_count = 0;
        result_count = 0;
        hold_cycles = 0;
        idle_enable = 1'b0;
        sink_hold = 1'b0;
        foreach (op_count[i]) op_count[i] = 0;
        foreach (acc_shadow[i]) begin
            acc_shadow[i] = '0;
            opnd_shadow[i] = '0;
        end
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(200);     // no idling on either side
        idle_enable = 1'b1;
        test_backpressure();
        test_random(1130);
        wait_drained();
        repeat (200) @(posedge i_clk);

        $display("covered %0d results: %0d writes, %0d matrix ops, %0d reads, %0d unused codes",
                 result_count, op_count[0] + op_count[1],
                 op_count[2] + op_count[3] + op_count[4] + op_count[5] + op_count[6]
                 + op_count[7], op_count[8],
                 op_count[9] + op_count[10] + op_count[11] + op_count[12] + op_count[13]
                 + op_count[14] + op_count[15]);
        if (error_count == 0 && result_queue.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/m4au_pkg.sv
rtl/m4au_if.sv
rtl/m4au_cell.sv
rtl/m4au_mac.sv
rtl/matrix4x4_arith_unit.sv
test/matrix4x4_arith_unit_tb.sv
